// ===== hw/rtl/srec_pkg.sv =====
// Shared types, character codes and the hex digit function of the S3 record encoder.
`timescale 1ns / 1ps

package srec_pkg;

    localparam logic [7:0] CH_S        = 8'h53;
    localparam logic [7:0] CH_3        = 8'h33;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] COUNT_EXTRA = 8'd5;

    // One finished record waiting for the character sequencer
    typedef struct packed {
        logic [7:0]  count;
        logic [31:0] addr;
        logic        last;
    } srec_desc_t;

    // Record queue status seen by both halves
    typedef struct packed {
        logic valid;
        logic full;
        logic rd_bank;
    } srec_dq_status_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        if (nib < 4'd10)
        begin
            return 8'h30 + wide;
        end
        return 8'h37 + wide;
    endfunction

endpackage

// ===== hw/rtl/srec_buf.sv =====
// Two-bank data byte store with one write port and a registered read port.
`timescale 1ns / 1ps

module srec_buf #(
    parameter int AW = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    localparam int DEPTH = 2 ** AW;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/srec_dq.sv =====
// Two-entry queue of finished records, one entry for each buffer bank.
`timescale 1ns / 1ps

module srec_dq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  srec_pkg::srec_desc_t      push_desc,
    input  logic                      pop,
    output srec_pkg::srec_desc_t      head,
    output srec_pkg::srec_dq_status_t status
);

    import srec_pkg::*;

    srec_desc_t entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

    assign head           = entry_reg[rptr_reg];
    assign status.valid   = (count_reg != 2'd0);
    assign status.full    = (count_reg == 2'd2);
    assign status.rd_bank = rptr_reg;

endmodule

// ===== hw/rtl/srec_front.sv =====
// Byte intake: fills the current bank, tracks offsets and closes records.
`timescale 1ns / 1ps

module srec_front #(
    parameter int N = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [31:0]              cfg_wdata,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               data_byte,
    input  logic                     final_byte,
    input  srec_pkg::srec_dq_status_t dq_status,
    output logic                     buf_we,
    output logic [$clog2(N > 1 ? N : 2):0] buf_waddr,
    output logic [7:0]               buf_wdata,
    output logic                     desc_push,
    output srec_pkg::srec_desc_t     desc
);

    import srec_pkg::*;

    localparam int IDX_W = $clog2(N > 1 ? N : 2);
    localparam int CNT_W = $clog2(N + 1);

    logic [31:0]      base_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [31:0]      offset_reg;
    logic [31:0]      offset_next;
    logic [31:0]      start_reg;
    logic [31:0]      start_next;
    logic             bank_reg;
    logic             accept;
    logic [31:0]      start_cur;
    logic [CNT_W-1:0] fill_inc;
    logic             flush;

    assign full      = dq_status.full;
    assign accept    = push && !dq_status.full;
    assign start_cur = (fill_reg == '0) ? offset_reg : start_reg;
    assign fill_inc  = fill_reg + CNT_W'(1);
    assign flush     = final_byte || (fill_inc == CNT_W'(N));

    assign buf_we    = accept;
    assign buf_waddr = {bank_reg, fill_reg[IDX_W-1:0]};
    assign buf_wdata = data_byte;

    assign desc_push  = accept && flush;
    assign desc.count = {{(8 - CNT_W){1'b0}}, fill_inc} + COUNT_EXTRA;
    assign desc.addr  = base_reg + start_cur;
    assign desc.last  = final_byte;

    always_comb
    begin
        fill_next   = fill_reg;
        offset_next = offset_reg;
        start_next  = start_reg;
        if (accept)
        begin
            offset_next = offset_reg + 32'd1;
            start_next  = start_cur;
            fill_next   = fill_inc;
            if (flush)
            begin
                fill_next = '0;
            end
            // end of image: next byte opens a fresh image at the base
            if (final_byte)
            begin
                offset_next = 32'd0;
                start_next  = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= 32'd0;
            fill_reg   <= '0;
            offset_reg <= 32'd0;
            start_reg  <= 32'd0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            fill_reg   <= fill_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            if (desc_push)
            begin
                bank_reg <= ~bank_reg;
            end
        end
    end

endmodule

// ===== hw/rtl/srec_back.sv =====
// Character sequencer: walks one record and drives the result register.
`timescale 1ns / 1ps

module srec_back #(
    parameter int N = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  srec_pkg::srec_dq_status_t dq_status,
    input  srec_pkg::srec_desc_t     head,
    output logic                     desc_pop,
    output logic [$clog2(N > 1 ? N : 2):0] buf_raddr,
    input  logic [7:0]               buf_rdata,
    output logic                     empty,
    input  logic                     pop,
    output logic [7:0]               ascii_char,
    output logic                     record_end,
    output logic                     image_end
);

    import srec_pkg::*;

    localparam int IDX_W = $clog2(N > 1 ? N : 2);
    localparam int CNT_W = $clog2(N + 1);

    typedef enum logic [2:0] {
        PH_S,
        PH_3,
        PH_CNT,
        PH_ADDR,
        PH_DATA,
        PH_CK,
        PH_CR,
        PH_LF
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             nib_reg, nib_next;
    logic [1:0]       ab_reg, ab_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       byte_reg, byte_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       char_reg, char_next;
    logic             rec_end_reg, rec_end_next;
    logic             img_end_reg, img_end_next;

    logic             go;
    logic [7:0]       addr_byte;
    logic [7:0]       ck;
    logic [7:0]       dlen8;
    logic [CNT_W-1:0] dlen;

    assign go        = dq_status.valid && (!out_valid_reg || pop);
    assign ck        = ~sum_reg;
    assign dlen8     = head.count - COUNT_EXTRA;
    assign dlen      = dlen8[CNT_W-1:0];
    assign buf_raddr = {dq_status.rd_bank, idx_reg[IDX_W-1:0]};

    always_comb
    begin
        case (ab_reg)
            2'd0:    addr_byte = head.addr[31:24];
            2'd1:    addr_byte = head.addr[23:16];
            2'd2:    addr_byte = head.addr[15:8];
            2'd3:    addr_byte = head.addr[7:0];
            default: addr_byte = head.addr[7:0];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        nib_next       = nib_reg;
        ab_next        = ab_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        rec_end_next   = rec_end_reg;
        img_end_next   = img_end_reg;
        desc_pop       = 1'b0;
        if (!go && pop)
        begin
            out_valid_next = 1'b0;
        end
        if (go)
        begin
            out_valid_next = 1'b1;
            rec_end_next   = 1'b0;
            img_end_next   = 1'b0;
            case (phase_reg)
                PH_S:
                begin
                    char_next  = CH_S;
                    sum_next   = head.count;
                    phase_next = PH_3;
                end
                PH_3:
                begin
                    char_next  = CH_3;
                    nib_next   = 1'b0;
                    phase_next = PH_CNT;
                end
                PH_CNT:
                begin
                    char_next = hex_char(nib_reg ? head.count[3:0] : head.count[7:4]);
                    nib_next  = ~nib_reg;
                    if (nib_reg)
                    begin
                        ab_next    = 2'd0;
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    char_next = hex_char(nib_reg ? addr_byte[3:0] : addr_byte[7:4]);
                    nib_next  = ~nib_reg;
                    if (nib_reg)
                    begin
                        sum_next = sum_reg + addr_byte;
                        ab_next  = ab_reg + 2'd1;
                        if (ab_reg == 2'd3)
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    nib_next = ~nib_reg;
                    if (!nib_reg)
                    begin
                        // hold the byte and advance the read address for the next one
                        char_next = hex_char(buf_rdata[7:4]);
                        byte_next = buf_rdata;
                        idx_next  = idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        char_next = hex_char(byte_reg[3:0]);
                        sum_next  = sum_reg + byte_reg;
                        if (idx_reg == dlen)
                        begin
                            phase_next = PH_CK;
                        end
                    end
                end
                PH_CK:
                begin
                    char_next = hex_char(nib_reg ? ck[3:0] : ck[7:4]);
                    nib_next  = ~nib_reg;
                    if (nib_reg)
                    begin
                        phase_next = PH_CR;
                    end
                end
                PH_CR:
                begin
                    char_next  = CH_CR;
                    phase_next = PH_LF;
                end
                PH_LF:
                begin
                    char_next    = CH_LF;
                    rec_end_next = 1'b1;
                    img_end_next = head.last;
                    desc_pop     = 1'b1;
                    idx_next     = '0;
                    phase_next   = PH_S;
                end
                default:
                begin
                    phase_next = PH_S;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_S;
            nib_reg       <= 1'b0;
            ab_reg        <= 2'd0;
            idx_reg       <= '0;
            sum_reg       <= 8'd0;
            byte_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
            char_reg      <= 8'd0;
            rec_end_reg   <= 1'b0;
            img_end_reg   <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            nib_reg       <= nib_next;
            ab_reg        <= ab_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            byte_reg      <= byte_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            rec_end_reg   <= rec_end_next;
            img_end_reg   <= img_end_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign ascii_char = char_reg;
    assign record_end = rec_end_reg;
    assign image_end  = img_end_reg;

endmodule

// ===== hw/rtl/srec_s3_record_encoder_unit.sv =====
// Top level of the S3 record encoder: intake, record queue, byte store, sequencer.
// Usage:
//   Input queue: present data_byte and final_byte with push; a transfer happens
//   when push is high and full is low. Each byte goes into the current bank of
//   a two-bank store; a bank closes as a record when it holds RECORD_DATA_BYTES
//   bytes or when final_byte is set.
//   Result queue: while empty is low, ascii_char, record_end and image_end show
//   the oldest character; pop high takes it. record_end marks the closing LF,
//   image_end the LF of the record closed by final_byte.
//   cfg_we loads cfg_wdata into the base address, used when a record closes.
//   With the sequencer idle, the closed record passes through the record queue
//   and the sequencer then registers the leading 'S' into the character register.
//   Throughput: while pop keeps up, the sequencer puts out one character per cycle;
//   a record of L bytes is 16 + 2*L characters and a full 16-byte record is 48
//   characters. Input runs freely while a bank is free.
//   full is high while both banks hold closed records, until the sequencer
//   loads the LF of the older one.
//   When the receiver stalls, the character register holds and the sequencer
//   waits; intake carries on into the free bank.
//   Reset clears the base address, offsets, fill count and both queues.
`timescale 1ns / 1ps

module srec_s3_record_encoder_unit #(
    parameter int RECORD_DATA_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  ascii_char,
    output logic        record_end,
    output logic        image_end
);

    import srec_pkg::*;

    localparam int IDX_W = $clog2(RECORD_DATA_BYTES > 1 ? RECORD_DATA_BYTES : 2);

    srec_dq_status_t dq_status;
    srec_desc_t      push_desc;
    srec_desc_t      head;
    logic            desc_push;
    logic            desc_pop;
    logic            buf_we;
    logic [IDX_W:0]  buf_waddr;
    logic [7:0]      buf_wdata;
    logic [IDX_W:0]  buf_raddr;
    logic [7:0]      buf_rdata;

    srec_front #(
        .N(RECORD_DATA_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .dq_status  (dq_status),
        .buf_we     (buf_we),
        .buf_waddr  (buf_waddr),
        .buf_wdata  (buf_wdata),
        .desc_push  (desc_push),
        .desc       (push_desc)
    );

    srec_dq u_dq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .push_desc (push_desc),
        .pop       (desc_pop),
        .head      (head),
        .status    (dq_status)
    );

    srec_buf #(
        .AW(IDX_W + 1)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (buf_waddr),
        .wr_data (buf_wdata),
        .rd_addr (buf_raddr),
        .rd_data (buf_rdata)
    );

    srec_back #(
        .N(RECORD_DATA_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .dq_status  (dq_status),
        .head       (head),
        .desc_pop   (desc_pop),
        .buf_raddr  (buf_raddr),
        .buf_rdata  (buf_rdata),
        .empty      (empty),
        .pop        (pop),
        .ascii_char (ascii_char),
        .record_end (record_end),
        .image_end  (image_end)
    );

endmodule

// ===== hw/rtl/srec_chk.sv =====
// Port-level checks of the S3 record encoder and their bind to the top level.
`timescale 1ns / 1ps

module srec_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] ascii_char,
    input logic       record_end,
    input logic       image_end
);

    import srec_pkg::*;

    // image end only ever marks the closing character of a record
    a_img_on_rec: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && image_end) |-> record_end)
        else $error("image_end without record_end");

    a_rec_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && record_end) |-> (ascii_char == CH_LF))
        else $error("record_end on a character other than LF");

    // LF never occurs inside a record, so every LF closes one
    a_lf_is_rec: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ascii_char == CH_LF) |-> record_end)
        else $error("LF without record_end");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(ascii_char) && $stable(record_end)))
        else $error("stalled character changed");

endmodule

bind srec_s3_record_encoder_unit srec_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .ascii_char (ascii_char),
    .record_end (record_end),
    .image_end  (image_end)
);

// ===== dv/tb.sv =====
// Self-checking bench for the S3 record encoder: byte stream in, record text out.
`timescale 1ns / 1ps

module tb;

    import srec_pkg::*;

    // Expected record text, built byte by byte as the encoder should see it
    class s3_record_board;
        localparam int REC_BYTES = 16;

        typedef struct {
            logic [7:0] ch;
            logic       rec_end;
            logic       img_end;
        } s3_char_t;

        logic [31:0] base_addr = '0;
        logic [7:0]  rec_bytes[REC_BYTES];
        int unsigned fill = 0;
        logic [31:0] img_offset = '0;
        logic [31:0] rec_offset = '0;
        s3_char_t    pending[$];
        int          errors = 0;

        task report(string msg);
            if (errors < 40)
            begin
                $display("%0t: %s", $time, msg);
            end
            errors++;
        endtask

        function void add_char(logic [7:0] ch, logic rec_end, logic img_end);
            s3_char_t c;
            c.ch = ch;
            c.rec_end = rec_end;
            c.img_end = img_end;
            pending = {pending, c};
        endfunction

        function void add_hex(logic [7:0] v);
            string digits;
            digits = "0123456789ABCDEF";
            add_char(digits[v[7:4]], 1'b0, 1'b0);
            add_char(digits[v[3:0]], 1'b0, 1'b0);
        endfunction

        function void encode_record(logic last);
            logic [7:0]  count;
            logic [31:0] addr;
            logic [7:0]  sum;
            count = 8'(fill + 5);
            addr = base_addr + rec_offset;
            sum = count;
            add_char(CH_S, 1'b0, 1'b0);
            add_char(CH_3, 1'b0, 1'b0);
            add_hex(count);
            for (int s = 3; s >= 0; s--)
            begin
                sum += addr[s * 8 +: 8];
                add_hex(addr[s * 8 +: 8]);
            end
            for (int i = 0; i < fill; i++)
            begin
                sum += rec_bytes[i];
                add_hex(rec_bytes[i]);
            end
            add_hex(~sum);
            add_char(CH_CR, 1'b0, 1'b0);
            add_char(CH_LF, 1'b1, last);
        endfunction

        // Note one accepted byte; a full buffer or the final byte closes a record
        function void take_byte(logic [7:0] b, logic last);
            if (fill == 0)
            begin
                rec_offset = img_offset;
            end
            if (fill < REC_BYTES)
            begin
                rec_bytes[fill] = b;
                fill++;
            end
            img_offset++;
            if (last || fill >= REC_BYTES)
            begin
                encode_record(last);
                fill = 0;
                if (last)
                begin
                    img_offset = '0;
                    rec_offset = '0;
                end
            end
        endfunction

        task check_char(logic [7:0] ch, logic rec_end, logic img_end);
            s3_char_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("character %h with nothing expected", ch));
                return;
            end
            want = pending.pop_front();
            if (ch !== want.ch)
            begin
                report($sformatf("ascii_char %h, expected %h", ch, want.ch));
            end
            if (rec_end !== want.rec_end)
            begin
                report($sformatf("record_end %b, expected %b on %h", rec_end, want.rec_end,
                    want.ch));
            end
            if (img_end !== want.img_end)
            begin
                report($sformatf("image_end %b, expected %b on %h", img_end, want.img_end,
                    want.ch));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  data_byte = '0;
    logic        final_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  ascii_char;
    logic        record_end;
    logic        image_end;

    s3_record_board board;
    int          bytes_sent = 0;
    bit          push_calm = 1'b0;
    bit          pop_calm = 1'b0;
    int          pop_wait = 0;

    srec_s3_record_encoder_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .empty      (empty),
        .pop        (pop),
        .ascii_char (ascii_char),
        .record_end (record_end),
        .image_end  (image_end)
    );

    always #4 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("tb failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none at all in a calm stretch
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Check the transfer at this edge, then decide pop for the next one
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            board.check_char(ascii_char, record_end, image_end);
        end
        if ($urandom_range(0, 299) == 0)
        begin
            pop_calm = !pop_calm;
        end
        if (pop_wait > 0)
        begin
            pop <= 1'b0;
            pop_wait--;
        end
        else
        begin
            pop <= 1'b1;
            pop_wait = pick_gap(pop_calm);
        end
    end

    task automatic set_base(input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.base_addr = v;
    endtask

    // Keep push high across back-to-back transfers; drop it only for a gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap(push_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        final_byte <= last;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        board.take_byte(b, last);
        bytes_sent++;
    endtask

    task automatic drain_records();
        push <= 1'b0;
        while (board.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int images;
        int len;
        bit broken;
        logic [31:0] base;

        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-byte images at the top of the address space
        set_base(32'hFFFF_FFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Full record, then base moved mid-image so the next address wraps
        for (int i = 0; i < 16; i++)
        begin
            send_byte(i == 0 ? 8'h00 : (i == 15 ? 8'hFF : 8'($urandom)), 1'b0);
        end
        send_byte(8'h5A, 1'b0);
        drain_records();
        set_base(32'hFFFF_FFF8);
        send_byte(8'hA5, 1'b1);
        drain_records();

        phase = 0;
        while (bytes_sent < 230)
        begin
            case (phase % 5)
                0: base = 32'h0000_0000;
                1: base = 32'hFFFF_FFFF;
                2: base = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
                default: base = $urandom;
            endcase
            set_base(base);
            push_calm = ($urandom_range(0, 3) == 0);
            images = $urandom_range(1, 3);
            for (int m = 0; m < images; m++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    len = 16 * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
                end
                else
                begin
                    len = $urandom_range(1, 24);
                end
                // Leave the last image open now and then; the next base applies to it
                broken = (m == images - 1) && ($urandom_range(0, 4) == 0);
                for (int i = 0; i < len; i++)
                begin
                    send_byte(8'($urandom), (i == len - 1) && !broken);
                end
            end
            drain_records();
            phase++;
        end

        send_byte(8'($urandom), 1'b1);
        drain_records();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
